### sv/particle_pool_engine_unit_macros.svh
// Assertion macros used by the particle pool top-level module.
`ifndef PARTICLE_POOL_ENGINE_UNIT_MACROS_SVH
`define PARTICLE_POOL_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH
`define PPE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("particle pool check failed");
`define PPE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("particle pool check failed");
`else
`define PPE_ASSERT_IMP(label, ante, cons)
`define PPE_ASSERT_NXT(label, ante, cons)
`endif

`endif

### sv/ppe_pkg.sv
`default_nettype none

package ppe_pkg;

  localparam int POOL_SIZE  = 64;
  localparam int SLOT_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int SLOT_OUT_W = 6;

  localparam int DT_W    = 16;
  localparam int POS_W   = 24;
  localparam int LIFE_W  = 17;
  localparam int ALPHA_W = 17;
  localparam int GREY_W  = 8;
  localparam int JIT_W   = 7;
  localparam int SHADE_W = 7;
  localparam int FADE_W  = DT_W + 2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SIZE - 1);
  localparam logic [LIFE_W-1:0] ONE_Q16   = LIFE_W'(65536);
  localparam logic [GREY_W-1:0] GREY_BASE = GREY_W'(50);

  typedef enum logic {
    CMD_SPAWN = 1'b0,
    CMD_TICK  = 1'b1
  } ppe_cmd_t;

  typedef enum logic {
    KIND_SPAWN = 1'b0,
    KIND_LIVE  = 1'b1
  } ppe_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SPWR,
    ST_TICK,
    ST_FLUSH
  } ppe_state_t;

  typedef enum logic [1:0] {
    OL_NONE,
    OL_SPAWN,
    OL_PEND
  } ppe_oload_t;

  // One pool entry as held in the slot memory
  typedef struct packed {
    logic [LIFE_W-1:0]  life;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [POS_W-1:0]   vx;
    logic [POS_W-1:0]   vy;
    logic [ALPHA_W-1:0] alpha;
    logic [GREY_W-1:0]  grey;
  } ppe_word_t;

  localparam int WORD_W = $bits(ppe_word_t);

  typedef struct packed {
    ppe_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [ALPHA_W-1:0] alpha;
    logic [GREY_W-1:0]  grey;
  } ppe_res_t;

  typedef struct packed {
    logic              capture;
    logic              adv;
    logic              spawn_wr;
    logic              pend_load;
    ppe_oload_t        out_load;
    logic              out_last;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
  } ppe_ctl_t;

endpackage

`default_nettype wire

### sv/particle_pool_engine_unit.sv
// Particle pool: a fixed set of POOL_SIZE slots held in one slot memory.
// Input channel (in_valid/in_ready) takes one command per transfer:
//   spawn - scan the live bits from the last used slot round the pool for a
//           free slot (slot 0 if none), write the new particle, return one
//           acknowledgement with out_last set.
//   tick  - sweep every slot through a three-stage read/update/write pipe,
//           return each particle still alive in slot order, out_last on the
//           final one; a tick that leaves nothing alive returns nothing.
// Result channel (out_valid/out_ready) is a single output register; one live
// result is held back so that out_last can be set on the final one.
// A spawn scans one slot per cycle; a tick sweeps one slot per cycle over the
// slot memory port while the receiver is ready.
// A receiver stall freezes the whole sweep until the waiting result is taken;
// the next command is taken while the last result still waits.
// Reset clears all live bits (every slot dead) and the last-used slot; the
// slot memory itself is not cleared.
`default_nettype none
`include "particle_pool_engine_unit_macros.svh"

module particle_pool_engine_unit import ppe_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic                     in_command,
  input  wire logic [DT_W-1:0]          in_time_step,
  input  wire logic signed [POS_W-1:0]  in_source_x,
  input  wire logic signed [POS_W-1:0]  in_source_y,
  input  wire logic signed [POS_W-1:0]  in_source_vx,
  input  wire logic signed [POS_W-1:0]  in_source_vy,
  input  wire logic signed [POS_W-1:0]  in_spawn_offset_x,
  input  wire logic signed [POS_W-1:0]  in_spawn_offset_y,
  input  wire logic signed [JIT_W-1:0]  in_jitter_tenths,
  input  wire logic [SHADE_W-1:0]       in_shade_hundredths,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic                     out_report_kind,
  output      logic [SLOT_OUT_W-1:0]    out_slot,
  output      logic signed [POS_W-1:0]  out_position_x,
  output      logic signed [POS_W-1:0]  out_position_y,
  output      logic [ALPHA_W-1:0]       out_alpha,
  output      logic [GREY_W-1:0]        out_grey_hundredths,
  output      logic                     out_last
);

  ppe_ctl_t   ctl;
  logic       b_live;
  ppe_word_t  ram_rdata;
  ppe_word_t  ram_wdata;
  logic [WORD_W-1:0] ram_rdata_bits;

  ppe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .b_live     (b_live),
    .ctl        (ctl)
  );

  ppe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (POOL_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (ctl.ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.ram_re),
    .raddr (ctl.ram_raddr),
    .rdata (ram_rdata_bits)
  );

  assign ram_rdata = ram_rdata_bits;

  ppe_dp u_dp (
    .clk                 (clk),
    .ctl                 (ctl),
    .in_time_step        (in_time_step),
    .in_source_x         (in_source_x),
    .in_source_y         (in_source_y),
    .in_source_vx        (in_source_vx),
    .in_source_vy        (in_source_vy),
    .in_spawn_offset_x   (in_spawn_offset_x),
    .in_spawn_offset_y   (in_spawn_offset_y),
    .in_jitter_tenths    (in_jitter_tenths),
    .in_shade_hundredths (in_shade_hundredths),
    .ram_rdata           (ram_rdata),
    .ram_wdata           (ram_wdata),
    .b_live              (b_live),
    .out_report_kind     (out_report_kind),
    .out_slot            (out_slot),
    .out_position_x      (out_position_x),
    .out_position_y      (out_position_y),
    .out_alpha           (out_alpha),
    .out_grey_hundredths (out_grey_hundredths),
    .out_last            (out_last)
  );

  // Write-back never lands on the entry being read in the same cycle
  `PPE_ASSERT_IMP(a_no_rw_clash, ctl.ram_we && ctl.ram_re, ctl.ram_waddr != ctl.ram_raddr)
  // A new result is loaded only when the output register is free or draining
  `PPE_ASSERT_IMP(a_no_out_overwrite, ctl.out_load != OL_NONE, !out_valid || out_ready)
  // Nothing of the previous command is still in flight when a new one is taken
  `PPE_ASSERT_IMP(a_idle_drained, in_ready, !ctl.ram_we && !ctl.pend_load)
  // A transfer on the input side makes the block busy in the next cycle
  `PPE_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

### sv/ppe_ram.sv
`default_nettype none

module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output      logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/ppe_ctrl.sv
`default_nettype none

module ppe_ctrl import ppe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire logic in_command,
  output      logic out_valid,
  input  wire logic out_ready,
  input  wire logic b_live,
  output      ppe_ctl_t ctl
);

  ppe_state_t            state_r, state_nxt;
  logic [POOL_SIZE-1:0]  alive_r, alive_nxt;
  logic [SLOT_W-1:0]     last_used_r, last_used_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  b_v_r, b_v_nxt;
  logic [SLOT_W-1:0]     b_idx_r, b_idx_nxt;
  logic                  b_alive_r, b_alive_nxt;
  logic                  c_v_r, c_v_nxt;
  logic [SLOT_W-1:0]     c_idx_r, c_idx_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  adv;

  // Hold the whole sweep while a finished result waits downstream
  assign adv = !(out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alive_r     <= '0;
      last_used_r <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alive_r     <= alive_nxt;
      last_used_r <= last_used_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      b_v_r       <= b_v_nxt;
      c_v_r       <= c_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    b_idx_r   <= b_idx_nxt;
    b_alive_r <= b_alive_nxt;
    c_idx_r   <= c_idx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    alive_nxt     = alive_r;
    last_used_nxt = last_used_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    b_v_nxt       = b_v_r;
    b_idx_nxt     = b_idx_r;
    b_alive_nxt   = b_alive_r;
    c_v_nxt       = c_v_r;
    c_idx_nxt     = c_idx_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;

    ctl           = '0;
    ctl.out_load  = OL_NONE;
    ctl.adv       = adv;
    ctl.ram_raddr = idx_r;
    ctl.ram_waddr = c_idx_r;
    ctl.ram_re    = adv && (state_r == ST_TICK);

    // Tick sweep: issue read, update life, write back and report
    if (adv) begin
      b_v_nxt     = (state_r == ST_TICK);
      b_idx_nxt   = idx_r;
      b_alive_nxt = alive_r[idx_r];
      c_v_nxt     = b_v_r && b_alive_r && b_live;
      c_idx_nxt   = b_idx_r;
      if (b_v_r) begin
        alive_nxt[b_idx_r] = b_alive_r && b_live;
      end
      if (c_v_r) begin
        ctl.ram_we    = 1'b1;
        ctl.pend_load = 1'b1;
        pend_v_nxt    = 1'b1;
        // Previous live particle is not the final one: release it
        if (pend_v_r) begin
          ctl.out_load  = OL_PEND;
          out_valid_nxt = 1'b1;
        end
      end
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          if (ppe_cmd_t'(in_command) == CMD_SPAWN) begin
            state_nxt = ST_SRCH;
            idx_nxt   = last_used_r;
            cnt_nxt   = '0;
          end else begin
            state_nxt = ST_TICK;
            idx_nxt   = '0;
          end
        end
      end
      ST_SRCH: begin
        if (!alive_r[idx_r]) begin
          slot_nxt  = idx_r;
          state_nxt = ST_SPWR;
        end else if (cnt_r == LAST_SLOT) begin
          // Pool full: reuse slot zero
          slot_nxt  = '0;
          state_nxt = ST_SPWR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          idx_nxt = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
        end
      end
      ST_SPWR: begin
        if (adv) begin
          ctl.ram_we         = 1'b1;
          ctl.ram_waddr      = slot_r;
          ctl.spawn_wr       = 1'b1;
          ctl.out_load       = OL_SPAWN;
          out_valid_nxt      = 1'b1;
          alive_nxt[slot_r]  = 1'b1;
          last_used_nxt      = slot_r;
          state_nxt          = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (adv) begin
          if (idx_r == LAST_SLOT) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!b_v_r && !c_v_r) begin
          if (!pend_v_r) begin
            state_nxt = ST_IDLE;
          end else if (adv) begin
            ctl.out_load  = OL_PEND;
            ctl.out_last  = 1'b1;
            out_valid_nxt = 1'b1;
            pend_v_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### sv/ppe_dp.sv
`default_nettype none

module ppe_dp import ppe_pkg::*; (
  input  wire logic                       clk,
  input  wire ppe_ctl_t                   ctl,
  input  wire logic [DT_W-1:0]            in_time_step,
  input  wire logic signed [POS_W-1:0]    in_source_x,
  input  wire logic signed [POS_W-1:0]    in_source_y,
  input  wire logic signed [POS_W-1:0]    in_source_vx,
  input  wire logic signed [POS_W-1:0]    in_source_vy,
  input  wire logic signed [POS_W-1:0]    in_spawn_offset_x,
  input  wire logic signed [POS_W-1:0]    in_spawn_offset_y,
  input  wire logic signed [JIT_W-1:0]    in_jitter_tenths,
  input  wire logic [SHADE_W-1:0]         in_shade_hundredths,
  input  wire ppe_word_t                  ram_rdata,
  output      ppe_word_t                  ram_wdata,
  output      logic                       b_live,
  output      logic                       out_report_kind,
  output      logic [SLOT_OUT_W-1:0]      out_slot,
  output      logic signed [POS_W-1:0]    out_position_x,
  output      logic signed [POS_W-1:0]    out_position_y,
  output      logic [ALPHA_W-1:0]         out_alpha,
  output      logic [GREY_W-1:0]          out_grey_hundredths,
  output      logic                       out_last
);

  // x / 10 == (x * DIV10_MUL) >> DIV10_SH for every |x| <= 2^23
  localparam logic [POS_W-1:0] DIV10_MUL = POS_W'(13421773);
  localparam int               DIV10_SH  = 27;
  // x / 5 == (x * JIT_MUL) >> JIT_SH for x <= 8192
  localparam logic [15:0]      JIT_MUL   = 16'd52429;
  localparam int               JIT_SH    = 18;
  localparam int               JX_W      = JIT_W + 7;

  function automatic logic [POS_W-1:0] div10(input logic [POS_W-1:0] v);
    logic                 neg;
    logic [POS_W-1:0]     mag;
    logic [2*POS_W-1:0]   prod;
    logic [POS_W-1:0]     q;
    neg  = v[POS_W-1];
    mag  = neg ? (~v + 1'b1) : v;
    prod = (2*POS_W)'(mag) * (2*POS_W)'(DIV10_MUL);
    q    = POS_W'(prod >> DIV10_SH);
    return neg ? (~q + 1'b1) : q;
  endfunction

  // Jitter tenths to Q15.8: j * 128 / 5, truncated toward zero
  function automatic logic [POS_W-1:0] jitter_q8(input logic [JIT_W-1:0] j);
    logic                neg;
    logic [JIT_W-1:0]    mag;
    logic [JX_W-1:0]     x;
    logic [JX_W+15:0]    prod;
    logic [POS_W-1:0]    q;
    neg  = j[JIT_W-1];
    mag  = neg ? (~j + 1'b1) : j;
    x    = {mag, 7'b0};
    prod = (JX_W+16)'(x) * (JX_W+16)'(JIT_MUL);
    q    = POS_W'(prod >> JIT_SH);
    return neg ? (~q + 1'b1) : q;
  endfunction

  logic [DT_W-1:0]    dt_r;
  logic [FADE_W-1:0]  fade_r;
  logic [POS_W-1:0]   src_x_r, src_y_r, src_vx_r, src_vy_r, off_x_r, off_y_r;
  logic [JIT_W-1:0]   jit_r;
  logic [SHADE_W-1:0] shade_r;
  logic [POS_W-1:0]   vel_x_r, vel_y_r, jit_q_r;
  ppe_word_t          c_word_r;
  logic [POS_W-1:0]   c_dx_r, c_dy_r;
  ppe_res_t           pend_r, out_r;
  logic               out_last_r;

  logic [DT_W+2:0]             fade5;
  logic [LIFE_W-1:0]           dt_ext;
  logic [LIFE_W-1:0]           life_dec;
  logic signed [DT_W:0]        dt_s;
  logic signed [POS_W+DT_W:0]  prod_x, prod_y;
  logic [ALPHA_W:0]            alpha_ext;
  logic [ALPHA_W-1:0]          alpha_new;
  ppe_word_t                   b_word;
  ppe_word_t                   tick_word, spawn_word;
  ppe_res_t                    tick_res, spawn_res;

  assign fade5 = {1'b0, in_time_step, 2'b00} + {3'b000, in_time_step};

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      dt_r     <= in_time_step;
      fade_r   <= fade5[DT_W+2:1];
      src_x_r  <= in_source_x;
      src_y_r  <= in_source_y;
      src_vx_r <= in_source_vx;
      src_vy_r <= in_source_vy;
      off_x_r  <= in_spawn_offset_x;
      off_y_r  <= in_spawn_offset_y;
      jit_r    <= in_jitter_tenths;
      shade_r  <= in_shade_hundredths;
    end
    vel_x_r <= div10(src_vx_r);
    vel_y_r <= div10(src_vy_r);
    jit_q_r <= jitter_q8(jit_r);
  end

  // Sweep stage B: entry just read from the slot memory
  assign dt_ext   = LIFE_W'(dt_r);
  assign life_dec = (ram_rdata.life > dt_ext) ? ram_rdata.life - dt_ext : '0;
  assign b_live   = (life_dec != '0);
  assign dt_s     = $signed({1'b0, dt_r});
  assign prod_x   = $signed(ram_rdata.vx) * dt_s;
  assign prod_y   = $signed(ram_rdata.vy) * dt_s;

  always_comb begin
    b_word      = ram_rdata;
    b_word.life = life_dec;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      c_word_r      <= b_word;
      // floor(v * dt / 2^16), low bits only since position wraps
      c_dx_r        <= prod_x[POS_W+DT_W-1:DT_W];
      c_dy_r        <= prod_y[POS_W+DT_W-1:DT_W];
    end
  end

  // Sweep stage C: move and fade
  assign alpha_ext = {1'b0, c_word_r.alpha};
  assign alpha_new = ((ALPHA_W+1)'(alpha_ext) > (ALPHA_W+1)'(fade_r)) ?
                     ALPHA_W'(alpha_ext - (ALPHA_W+1)'(fade_r)) : '0;

  always_comb begin
    tick_word       = c_word_r;
    tick_word.px    = c_word_r.px - c_dx_r;
    tick_word.py    = c_word_r.py - c_dy_r;
    tick_word.alpha = alpha_new;

    spawn_word.life  = ONE_Q16;
    spawn_word.px    = src_x_r + jit_q_r + off_x_r;
    spawn_word.py    = src_y_r + jit_q_r + off_y_r;
    spawn_word.vx    = vel_x_r;
    spawn_word.vy    = vel_y_r;
    spawn_word.alpha = ONE_Q16;
    spawn_word.grey  = GREY_BASE + GREY_W'(shade_r);

    tick_res.kind  = KIND_LIVE;
    tick_res.slot  = ctl.ram_waddr;
    tick_res.px    = tick_word.px;
    tick_res.py    = tick_word.py;
    tick_res.alpha = tick_word.alpha;
    tick_res.grey  = tick_word.grey;

    spawn_res.kind  = KIND_SPAWN;
    spawn_res.slot  = ctl.ram_waddr;
    spawn_res.px    = spawn_word.px;
    spawn_res.py    = spawn_word.py;
    spawn_res.alpha = spawn_word.alpha;
    spawn_res.grey  = spawn_word.grey;
  end

  assign ram_wdata = ctl.spawn_wr ? spawn_word : tick_word;

  always_ff @(posedge clk) begin
    if (ctl.pend_load) begin
      pend_r <= tick_res;
    end
    case (ctl.out_load)
      OL_SPAWN: begin
        out_r      <= spawn_res;
        out_last_r <= 1'b1;
      end
      OL_PEND: begin
        out_r      <= pend_r;
        out_last_r <= ctl.out_last;
      end
      default: begin
        out_r      <= out_r;
        out_last_r <= out_last_r;
      end
    endcase
  end

  assign out_report_kind     = out_r.kind;
  assign out_slot            = SLOT_OUT_W'(out_r.slot);
  assign out_position_x      = $signed(out_r.px);
  assign out_position_y      = $signed(out_r.py);
  assign out_alpha           = out_r.alpha;
  assign out_grey_hundredths = out_r.grey;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire
